// ----- rtl/iss_pkg.sv -----
// ----------------------------------------------------------------------------
// iss_pkg
// Shared types and field widths of the insertion sort block.
// ----------------------------------------------------------------------------
package iss_pkg;

	localparam int unsigned FIELD_W = 16;
	localparam int unsigned CMP_W   = 9;
	localparam int unsigned MOV_W   = 10;

	typedef enum logic [1:0] {
		ST_FILL  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

	// Per-cycle command broadcast to every cell of the chain.
	typedef struct packed {
		logic insert;
		logic drain;
	} cell_ctrl_t;

endpackage

// ----- rtl/iss_in_if.sv -----
// ----------------------------------------------------------------------------
// iss_in_if
// Input channel: one value per request, with the end-of-set mark.
// ----------------------------------------------------------------------------
interface iss_in_if;
	logic                         valid;
	logic                         ready;
	logic [iss_pkg::FIELD_W-1:0]  value;
	logic                         last_item;

	modport source (output valid, output value, output last_item, input ready);
	modport sink   (input valid, input value, input last_item, output ready);
endinterface

// ----- rtl/iss_out_if.sv -----
// ----------------------------------------------------------------------------
// iss_out_if
// Result channel: one sorted value per request, with the set totals.
// ----------------------------------------------------------------------------
interface iss_out_if;
	logic                         valid;
	logic                         ready;
	logic [iss_pkg::FIELD_W-1:0]  sorted_value;
	logic [iss_pkg::CMP_W-1:0]    comparisons;
	logic [iss_pkg::MOV_W-1:0]    relocations;
	logic                         last_out;
	logic                         overflow;

	modport source (output valid, output sorted_value, output comparisons,
		output relocations, output last_out, output overflow, input ready);
	modport sink   (input valid, input sorted_value, input comparisons,
		input relocations, input last_out, input overflow, output ready);
endinterface

// ----- rtl/iss_cell.sv -----
// ----------------------------------------------------------------------------
// iss_cell
// One slot of the sorted chain: compares the broadcast key, takes the key,
// its lower neighbour's value on insertion, or its upper neighbour's value
// while draining.
// ----------------------------------------------------------------------------
module iss_cell #(
	parameter int unsigned KW = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  iss_pkg::cell_ctrl_t ctrl,
	input  logic [KW-1:0]       key,
	input  logic                prev_occ,
	input  logic                prev_gt,
	input  logic [KW-1:0]       prev_value,
	input  logic                next_occ,
	input  logic [KW-1:0]       next_value,
	output logic                occ,
	output logic                gt,
	output logic                here,
	output logic [KW-1:0]       value
);

	logic          occ_q;
	logic [KW-1:0] value_q;

	assign gt    = occ_q && (value_q > key);
	// insertion point: first slot that is greater, or the first free slot
	assign here  = !prev_gt && (gt || (!occ_q && prev_occ));
	assign occ   = occ_q;
	assign value = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctrl.insert) begin
			if (prev_gt || here) begin
				occ_q <= 1'b1;
			end
		end else if (ctrl.drain) begin
			occ_q <= next_occ;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (prev_gt) begin
				value_q <= prev_value;
			end else if (here) begin
				value_q <= key;
			end
		end else if (ctrl.drain) begin
			value_q <= next_value;
		end
	end

endmodule

// ----- rtl/insertion_sort_with_op_counts.sv -----
// ----------------------------------------------------------------------------
// insertion_sort_with_op_counts
// Sorts a set of values in a chain of compare-and-shift cells and counts the
// comparisons and relocations that a software insertion sort would make.
// ----------------------------------------------------------------------------
// Throughput: one value accepted per cycle while filling; the key is compared
//   in every cell at once and the chain shifts in the same cycle.
// Draining: the first result is offered the cycle after the last item is taken;
//   a set of N values then drains at one result per cycle while the receiver is ready.
// No input is taken while a set is draining.
// Reset clears occupancy, counts and the overflow flag; stored values are not
//   cleared, as empty cells are never read.
module insertion_sort_with_op_counts #(
	parameter int unsigned DEPTH       = 32,
	parameter int unsigned VALUE_WIDTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	iss_in_if.sink    items,
	iss_out_if.source results
);

	localparam int unsigned KW = (VALUE_WIDTH < iss_pkg::FIELD_W) ?
		VALUE_WIDTH : iss_pkg::FIELD_W;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	iss_pkg::state_t      state_q;
	iss_pkg::cell_ctrl_t  ctrl;
	logic [CW-1:0]        fill_q;
	logic [iss_pkg::CMP_W-1:0] cmp_q;
	logic [iss_pkg::MOV_W-1:0] mov_q;
	logic                 ovf_q;

	logic [DEPTH-1:0]     occ_w;
	logic [DEPTH-1:0]     gt_w;
	logic [DEPTH-1:0]     here_w;
	logic [KW-1:0]        val_w [DEPTH];
	logic [KW-1:0]        key;

	logic                 in_acc;
	logic                 out_acc;
	logic                 full;
	logic [CW-1:0]        pos;
	logic [CW-1:0]        shifted;

	assign key     = items.value[KW-1:0];
	assign in_acc  = items.valid && items.ready;
	assign out_acc = results.valid && results.ready;
	assign full    = (fill_q == CW'(DEPTH));

	assign items.ready = (state_q == iss_pkg::ST_FILL);

	assign ctrl.insert = in_acc && !full;
	assign ctrl.drain  = out_acc;

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		logic          p_occ;
		logic          p_gt;
		logic [KW-1:0] p_val;
		logic          n_occ;
		logic [KW-1:0] n_val;

		if (k == 0) begin : g_bot
			assign p_occ = 1'b1;
			assign p_gt  = 1'b0;
			assign p_val = '0;
		end else begin : g_mid
			assign p_occ = occ_w[k-1];
			assign p_gt  = gt_w[k-1];
			assign p_val = val_w[k-1];
		end

		if (k == DEPTH - 1) begin : g_top
			assign n_occ = 1'b0;
			assign n_val = '0;
		end else begin : g_low
			assign n_occ = occ_w[k+1];
			assign n_val = val_w[k+1];
		end

		iss_cell #(.KW(KW)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.key        (key),
			.prev_occ   (p_occ),
			.prev_gt    (p_gt),
			.prev_value (p_val),
			.next_occ   (n_occ),
			.next_value (n_val),
			.occ        (occ_w[k]),
			.gt         (gt_w[k]),
			.here       (here_w[k]),
			.value      (val_w[k])
		);
	end

	// insertion index from the one-hot insertion point
	always_comb begin
		pos = '0;
		for (int k = 0; k < DEPTH; k++) begin
			pos = pos | (here_w[k] ? CW'(k) : '0);
		end
	end

	assign shifted = fill_q - pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iss_pkg::ST_FILL;
			fill_q  <= '0;
			cmp_q   <= '0;
			mov_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			unique case (state_q)
				iss_pkg::ST_FILL: begin
					if (in_acc) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							fill_q <= fill_q + CW'(1);
							if (fill_q != '0) begin
								cmp_q <= cmp_q + iss_pkg::CMP_W'(shifted)
									+ iss_pkg::CMP_W'(pos != '0);
								mov_q <= mov_q + iss_pkg::MOV_W'(shifted)
									+ iss_pkg::MOV_W'(1);
							end
						end
						if (items.last_item) begin
							state_q <= iss_pkg::ST_DRAIN;
						end
					end
				end
				iss_pkg::ST_DRAIN: begin
					if (out_acc) begin
						fill_q <= fill_q - CW'(1);
						// final result taken: clear for the next set
						if (fill_q == CW'(1)) begin
							state_q <= iss_pkg::ST_FILL;
							cmp_q   <= '0;
							mov_q   <= '0;
							ovf_q   <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= iss_pkg::ST_FILL;
				end
			endcase
		end
	end

	assign results.valid        = (state_q == iss_pkg::ST_DRAIN);
	assign results.sorted_value = iss_pkg::FIELD_W'(val_w[0]);
	assign results.comparisons  = cmp_q;
	assign results.relocations  = mov_q;
	assign results.last_out     = (fill_q == CW'(1));
	assign results.overflow     = ovf_q;

	// occupancy bits track the fill count
	a_fill_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0) == !occ_w[0])
		else $error("fill count and bottom cell occupancy disagree");

	// occupied cells form a contiguous run from the bottom
	a_contig: assert property (@(posedge clk) disable iff (!arst_n)
		((occ_w >> 1) & ~occ_w) == '0)
		else $error("gap in occupied cells");

	// draining never starts from an empty chain
	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == iss_pkg::ST_DRAIN) |-> (fill_q != '0))
		else $error("draining with no stored values");

	// the final result returns the block to an empty, cleared state
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && results.last_out) |=>
			(state_q == iss_pkg::ST_FILL && fill_q == '0 && !ovf_q))
		else $error("set not cleared after final result");

	// a request taken while full raises the overflow flag
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && full && !items.last_item) |=> ovf_q)
		else $error("dropped request did not raise overflow");

endmodule

// ----- tb/tb_insertion_sort_with_op_counts.sv -----
// ----------------------------------------------------------------------------
// tb_insertion_sort_with_op_counts
// Sends sets of values through the sorter and checks every result. Each
// sorted value, both operation totals, the end mark and the overflow flag
// are compared against a shadow sorter kept in the bench.
// ----------------------------------------------------------------------------
module tb_insertion_sort_with_op_counts;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SORT_DEPTH  = 32;
	localparam int unsigned RESET_TICKS = 11;
	localparam int unsigned SETTLE      = 2 * SORT_DEPTH + 8;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned RANDOM_REQS = 350;

	typedef struct packed {
		logic [iss_pkg::FIELD_W-1:0] sorted_value;
		logic [iss_pkg::CMP_W-1:0]   comparisons;
		logic [iss_pkg::MOV_W-1:0]   relocations;
		logic                        last_out;
		logic                        overflow;
	} sorted_out_t;

	logic clk;
	logic arst_n;

	iss_in_if  items ();
	iss_out_if results ();

	insertion_sort_with_op_counts #(
		.DEPTH       (SORT_DEPTH),
		.VALUE_WIDTH (iss_pkg::FIELD_W)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items),
		.results (results)
	);

	// Shadow sorter state
	logic [iss_pkg::FIELD_W-1:0] shadow_store [SORT_DEPTH];
	int unsigned        shadow_fill;
	int unsigned        shadow_cmp;
	int unsigned        shadow_mov;
	logic               shadow_ovf;

	sorted_out_t pending_sorted [$];
	int unsigned mismatch_count;
	int unsigned cycle_count;
	bit          sender_idles;
	bit          receiver_stalls;
	bit          checks_live;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic void clear_shadow();
		shadow_fill = 0;
		shadow_cmp  = 0;
		shadow_mov  = 0;
		shadow_ovf  = 1'b0;
	endfunction

	// Insert one accepted value; on the set's end mark, queue the whole set.
	function automatic void predict_sorted_insert(logic [iss_pkg::FIELD_W-1:0] v, logic lst);
		int unsigned pos;
		sorted_out_t r;
		if (shadow_fill >= SORT_DEPTH) begin
			shadow_ovf = 1'b1;
		end else if (shadow_fill == 0) begin
			shadow_store[0] = v;
			shadow_fill = 1;
		end else begin
			pos = shadow_fill;
			while (pos > 0) begin
				shadow_cmp++;
				if (shadow_store[pos-1] <= v)
					break;
				shadow_store[pos] = shadow_store[pos-1];
				shadow_mov++;
				pos--;
			end
			shadow_store[pos] = v;
			shadow_mov++;
			shadow_fill++;
		end
		if (lst) begin
			for (int unsigned k = 0; k < shadow_fill; k++) begin
				r.sorted_value = shadow_store[k];
				r.comparisons  = iss_pkg::CMP_W'(shadow_cmp);
				r.relocations  = iss_pkg::MOV_W'(shadow_mov);
				r.last_out     = (k + 1 == shadow_fill);
				r.overflow     = shadow_ovf;
				pending_sorted = {pending_sorted, r};
			end
			clear_shadow();
		end
	endfunction

	task automatic send_request(input logic [iss_pkg::FIELD_W-1:0] v, input logic lst);
		int unsigned gap;
		gap = sender_idles ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			items.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items.valid     <= 1'b1;
		items.value     <= v;
		items.last_item <= lst;
		do @(posedge clk); while (!(items.valid && items.ready));
		predict_sorted_insert(v, lst);
	endtask

	// Hold the sender until every queued result has been taken.
	task automatic hold_until_drained();
		items.valid <= 1'b0;
		while (pending_sorted.size() != 0) @(posedge clk);
	endtask

	task automatic send_set(input int unsigned count, input int unsigned mode);
		logic [iss_pkg::FIELD_W-1:0] v;
		for (int unsigned i = 0; i < count; i++) begin
			case (mode)
				0: v = iss_pkg::FIELD_W'($urandom_range(0, 3));
				1: v = $urandom_range(0, 1) ? {iss_pkg::FIELD_W{1'b1}} : '0;
				default: v = iss_pkg::FIELD_W'($urandom());
			endcase
			send_request(v, i + 1 == count);
		end
	endtask

	// Result side: random stalls, then compare against the oldest expectation.
	initial begin
		sorted_out_t want;
		sorted_out_t got;
		int unsigned stall;
		results.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = receiver_stalls ? $urandom_range(0, 7) : 0;
			if (stall > 0) begin
				results.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			results.ready <= 1'b1;
			do @(posedge clk); while (!(results.valid && results.ready));
			got = '{results.sorted_value, results.comparisons, results.relocations,
				results.last_out, results.overflow};
			if (pending_sorted.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: unexpected result %p", $realtime, got);
			end else begin
				want = pending_sorted.pop_front();
				if (got.sorted_value !== want.sorted_value ||
					got.comparisons !== want.comparisons ||
					got.relocations !== want.relocations ||
					got.last_out !== want.last_out ||
					got.overflow !== want.overflow) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: result mismatch, expected %p, got %p",
							$realtime, want, got);
				end
			end
		end
	end

	task automatic test_single_value_sets();
		send_request('0, 1'b1);
		send_request({iss_pkg::FIELD_W{1'b1}}, 1'b1);
		send_request(16'hAAAA, 1'b0);
		send_request(16'h5555, 1'b1);
	endtask

	task automatic test_order_extremes();
		// Descending: every key walks to the bottom of the store
		send_request(16'hFFFF, 1'b0);
		send_request(16'd40000, 1'b0);
		send_request(16'd1000, 1'b0);
		send_request(16'd1, 1'b0);
		send_request(16'd0, 1'b1);
		// Ascending: every key stops at the first compare
		send_request(16'd0, 1'b0);
		send_request(16'd1, 1'b0);
		send_request(16'd2, 1'b0);
		send_request(16'hFFFE, 1'b0);
		send_request(16'hFFFF, 1'b1);
		// Equal keys keep arrival order and stop at once
		repeat (3) send_request(16'd7, 1'b0);
		send_request(16'd7, 1'b1);
		send_request(16'd9, 1'b0);
		send_request(16'd3, 1'b0);
		send_request(16'd9, 1'b0);
		send_request(16'd5, 1'b1);
	endtask

	task automatic test_full_and_overflow();
		receiver_stalls = 1'b1;
		// Exactly full, no drop
		send_set(SORT_DEPTH, 2);
		// Over capacity, end mark arrives on a dropped request
		for (int unsigned i = 0; i < SORT_DEPTH + 3; i++)
			send_request(iss_pkg::FIELD_W'(SORT_DEPTH + 3 - i), i == SORT_DEPTH + 2);
		hold_until_drained();
	endtask

	task automatic test_random_sets();
		int unsigned sent;
		int unsigned count;
		int unsigned pick;
		sent = 0;
		while (sent < RANDOM_REQS) begin
			if ($urandom_range(0, 5) == 0) sender_idles = ~sender_idles;
			if ($urandom_range(0, 5) == 0) receiver_stalls = ~receiver_stalls;
			pick = $urandom_range(0, 99);
			if (pick < 75)
				count = $urandom_range(1, 8);
			else if (pick < 95)
				count = $urandom_range(9, SORT_DEPTH);
			else
				count = $urandom_range(SORT_DEPTH + 1, SORT_DEPTH + 6);
			send_set(count, $urandom_range(0, 5));
			sent += count;
			if ($urandom_range(0, 15) == 0) hold_until_drained();
		end
	endtask

	task automatic test_pause_until_drained();
		sender_idles    = 1'b0;
		receiver_stalls = 1'b1;
		send_set(6, 2);
		hold_until_drained();
		send_set(1, 2);
		send_set(4, 0);
	endtask

	initial begin
		arst_n          = 1'b0;
		items.valid     = 1'b0;
		items.value     = '0;
		items.last_item = 1'b0;
		sender_idles    = 1'b0;
		receiver_stalls = 1'b0;
		clear_shadow();
		repeat (RESET_TICKS) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_value_sets();
		sender_idles = 1'b1;
		test_order_extremes();
		test_full_and_overflow();
		test_pause_until_drained();
		test_random_sets();

		hold_until_drained();
		repeat (SETTLE) @(posedge clk);
		if (mismatch_count == 0 && pending_sorted.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
